// ===== rtl/cbdq_pkg.sv =====
// Shared constants, types and ring-index helpers for the circular buffer deque.
package cbdq_pkg;

	localparam int MAX_ELEMENTS = 255;
	localparam int ELEMENT_BITS = 32;
	localparam int SLOT_COUNT   = MAX_ELEMENTS + 1;
	localparam int IDX_BITS     = (SLOT_COUNT > 2) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_BITS     = IDX_BITS + 1;

	localparam int FUNC_BITS    = 3;
	localparam int STATUS_BITS  = 2;

	typedef logic [IDX_BITS-1:0]     idx_t;
	typedef logic [CNT_BITS-1:0]     cnt_t;
	typedef logic [ELEMENT_BITS-1:0] elem_t;
	typedef logic [FUNC_BITS-1:0]    func_t;
	typedef logic [STATUS_BITS-1:0]  status_t;

	localparam func_t OP_NONE       = 3'd0;
	localparam func_t OP_ADD_FRONT  = 3'd1;
	localparam func_t OP_ADD_BACK   = 3'd2;
	localparam func_t OP_DROP_FRONT = 3'd3;
	localparam func_t OP_DROP_BACK  = 3'd4;
	localparam func_t OP_CLEAR      = 3'd5;

	localparam status_t STAT_OK         = 2'd0;
	localparam status_t STAT_FULL_REJ   = 2'd1;
	localparam status_t STAT_EMPTY_REJ  = 2'd2;

	localparam idx_t IDX_LAST = IDX_BITS'(SLOT_COUNT - 1);

	function automatic idx_t ring_next(input idx_t i);
		ring_next = (i == IDX_LAST) ? '0 : idx_t'(i + 1'b1);
	endfunction

	function automatic idx_t ring_prev(input idx_t i);
		ring_prev = (i == '0) ? IDX_LAST : idx_t'(i - 1'b1);
	endfunction

	function automatic cnt_t ring_count(input idx_t head, input idx_t tail);
		if (tail >= head) begin
			ring_count = cnt_t'(tail) - cnt_t'(head);
		end else begin
			ring_count = cnt_t'(tail) + cnt_t'(SLOT_COUNT) - cnt_t'(head);
		end
	endfunction

endpackage

// ===== rtl/cbdq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module cbdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/circular_buffer_deque_unit.sv =====
// Double-ended queue on a circular RAM store with one slot kept free.
//
// Command channel: a transaction is taken at a rising edge where start is high
// and busy is low; func selects none, push front, push back, pop front, pop
// back or clear, and value is the element to push.
// Result channel: done is high for exactly one cycle and carries front_value,
// back_value, fill_count, empty, is_full and status for that transaction.
// front_value and back_value read zero when the queue is empty.
// Sequence: the accepting edge moves head or tail and writes the pushed slot;
// in ST_READ the front and back slots are read from the RAM copies into
// registers and done is raised, so done is high in ST_RESP together with the
// read data. busy is high in ST_READ and ST_RESP, so a new transaction is
// taken only after the previous result has been shown.
// Rejected pushes (full) and pops (empty) leave the queue unchanged and report
// their status code.
// Reset (arst_n low) empties the queue: head and tail go to slot zero and the
// control returns to idle. Slot contents are not cleared; only written slots
// are ever reported. The receiver cannot stall; each result is shown once.
module circular_buffer_deque_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [2:0]                      func,
	input  logic signed [31:0]              value,
	output logic                            busy,
	output logic                            done,
	output logic signed [31:0]              front_value,
	output logic signed [31:0]              back_value,
	output logic [7:0]                      fill_count,
	output logic                            empty,
	output logic                            is_full,
	output logic [1:0]                      status
);

	typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_RESP} state_t;

	state_t              state_q;
	cbdq_pkg::idx_t      head_q;
	cbdq_pkg::idx_t      tail_q;
	cbdq_pkg::status_t   status_q;
	logic                done_q;

	logic                accept;
	logic                q_empty;
	logic                q_full;
	logic                wr_en;
	cbdq_pkg::idx_t      wr_addr;
	cbdq_pkg::elem_t     wr_data;
	cbdq_pkg::elem_t     front_rd;
	cbdq_pkg::elem_t     back_rd;
	cbdq_pkg::cnt_t      count;

	assign accept  = start && (state_q == ST_IDLE);
	assign busy    = (state_q != ST_IDLE);
	assign q_empty = (head_q == tail_q);
	assign q_full  = (cbdq_pkg::ring_next(tail_q) == head_q);
	assign wr_data = cbdq_pkg::elem_t'($unsigned(value));

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = tail_q;
		if (accept && !q_full) begin
			case (func)
				cbdq_pkg::OP_ADD_FRONT: begin
					wr_en   = 1'b1;
					wr_addr = cbdq_pkg::ring_prev(head_q);
				end
				cbdq_pkg::OP_ADD_BACK: begin
					wr_en   = 1'b1;
					wr_addr = tail_q;
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	// Two mirrored copies give one read port each for front and back.
	cbdq_ram #(
		.WIDTH (cbdq_pkg::ELEMENT_BITS),
		.DEPTH (cbdq_pkg::SLOT_COUNT)
	) u_ram_front (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (head_q),
		.rdata (front_rd)
	);

	cbdq_ram #(
		.WIDTH (cbdq_pkg::ELEMENT_BITS),
		.DEPTH (cbdq_pkg::SLOT_COUNT)
	) u_ram_back (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (cbdq_pkg::ring_prev(tail_q)),
		.rdata (back_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			status_q <= cbdq_pkg::STAT_OK;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						status_q <= cbdq_pkg::STAT_OK;
						state_q  <= ST_READ;
						case (func)
							cbdq_pkg::OP_ADD_FRONT: begin
								if (q_full) begin
									status_q <= cbdq_pkg::STAT_FULL_REJ;
								end else begin
									head_q <= cbdq_pkg::ring_prev(head_q);
								end
							end
							cbdq_pkg::OP_ADD_BACK: begin
								if (q_full) begin
									status_q <= cbdq_pkg::STAT_FULL_REJ;
								end else begin
									tail_q <= cbdq_pkg::ring_next(tail_q);
								end
							end
							cbdq_pkg::OP_DROP_FRONT: begin
								if (q_empty) begin
									status_q <= cbdq_pkg::STAT_EMPTY_REJ;
								end else begin
									head_q <= cbdq_pkg::ring_next(head_q);
								end
							end
							cbdq_pkg::OP_DROP_BACK: begin
								if (q_empty) begin
									status_q <= cbdq_pkg::STAT_EMPTY_REJ;
								end else begin
									tail_q <= cbdq_pkg::ring_prev(tail_q);
								end
							end
							cbdq_pkg::OP_CLEAR: begin
								head_q <= '0;
								tail_q <= '0;
							end
							default: begin
								status_q <= cbdq_pkg::STAT_OK;
							end
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_RESP;
					done_q  <= 1'b1;
				end
				ST_RESP: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign count       = cbdq_pkg::ring_count(head_q, tail_q);
	assign done        = done_q;
	assign front_value = q_empty ? '0 : 32'(front_rd);
	assign back_value  = q_empty ? '0 : 32'(back_rd);
	assign fill_count  = count[7:0];
	assign empty       = q_empty;
	assign is_full     = q_full;
	assign status      = status_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("result strobe missing two cycles after a transaction");

	assert property (@(posedge clk) disable iff (!arst_n)
		!(q_empty && q_full))
		else $error("queue flagged empty and full at once");

	assert property (@(posedge clk) disable iff (!arst_n)
		(head_q < cbdq_pkg::SLOT_COUNT) && (tail_q < cbdq_pkg::SLOT_COUNT))
		else $error("ring index out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> ($stable(head_q) && $stable(tail_q)))
		else $error("pointer moved without a transaction");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for circular_buffer_deque_unit with a ring-index deque predictor.
module testbench;

	localparam cbdq_pkg::func_t OP_SPARE_A  = 3'd6;
	localparam cbdq_pkg::func_t OP_SPARE_B  = 3'd7;
	localparam int unsigned     CYCLE_LIMIT = 300000;
	localparam int unsigned     MAX_GAP     = 40;
	localparam int unsigned     PEND_DEPTH  = 8;

	typedef struct {
		cbdq_pkg::elem_t   front;
		cbdq_pkg::elem_t   back;
		logic [7:0]        fill;
		logic              empty;
		logic              full;
		cbdq_pkg::status_t stat;
	} deque_view_t;

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	logic              start  = 1'b0;
	cbdq_pkg::func_t   func   = cbdq_pkg::OP_NONE;
	logic signed [31:0] value = '0;
	logic              busy;
	logic              done;
	logic signed [31:0] front_value;
	logic signed [31:0] back_value;
	logic [7:0]        fill_count;
	logic              empty;
	logic              is_full;
	logic [1:0]        status;

	cbdq_pkg::elem_t shadow_slots [cbdq_pkg::SLOT_COUNT];
	int unsigned shadow_head = 0;
	int unsigned shadow_tail = 0;
	deque_view_t expected_views [PEND_DEPTH];
	int unsigned pend_wr     = 0;
	int unsigned pend_rd     = 0;
	int unsigned idle_pct    = 6;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;

	circular_buffer_deque_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.func(func),
		.value(value),
		.busy(busy),
		.done(done),
		.front_value(front_value),
		.back_value(back_value),
		.fill_count(fill_count),
		.empty(empty),
		.is_full(is_full),
		.status(status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL circular_buffer_deque_unit");
			$finish;
		end
	end

	function automatic int unsigned wrap_up(input int unsigned i);
		return (i + 1) % cbdq_pkg::SLOT_COUNT;
	endfunction

	function automatic int unsigned wrap_down(input int unsigned i);
		return (i + cbdq_pkg::SLOT_COUNT - 1) % cbdq_pkg::SLOT_COUNT;
	endfunction

	function automatic int unsigned shadow_fill();
		return (shadow_tail + cbdq_pkg::SLOT_COUNT - shadow_head) % cbdq_pkg::SLOT_COUNT;
	endfunction

	function automatic deque_view_t apply_deque_op(input cbdq_pkg::func_t f,
			input cbdq_pkg::elem_t v);
		deque_view_t r;
		r.stat = cbdq_pkg::STAT_OK;
		case (f)
			cbdq_pkg::OP_ADD_FRONT, cbdq_pkg::OP_ADD_BACK: begin
				if (shadow_fill() == cbdq_pkg::MAX_ELEMENTS) begin
					r.stat = cbdq_pkg::STAT_FULL_REJ;
				end else if (f == cbdq_pkg::OP_ADD_FRONT) begin
					shadow_head = wrap_down(shadow_head);
					shadow_slots[shadow_head] = v;
				end else begin
					shadow_slots[shadow_tail] = v;
					shadow_tail = wrap_up(shadow_tail);
				end
			end
			cbdq_pkg::OP_DROP_FRONT, cbdq_pkg::OP_DROP_BACK: begin
				if (shadow_fill() == 0) begin
					r.stat = cbdq_pkg::STAT_EMPTY_REJ;
				end else if (f == cbdq_pkg::OP_DROP_FRONT) begin
					shadow_head = wrap_up(shadow_head);
				end else begin
					shadow_tail = wrap_down(shadow_tail);
				end
			end
			cbdq_pkg::OP_CLEAR: begin
				shadow_head = 0;
				shadow_tail = 0;
			end
			default: ;
		endcase
		r.fill  = 8'(shadow_fill());
		r.empty = (shadow_fill() == 0);
		r.full  = (shadow_fill() == cbdq_pkg::MAX_ELEMENTS);
		r.front = r.empty ? '0 : shadow_slots[shadow_head];
		r.back  = r.empty ? '0 : shadow_slots[wrap_down(shadow_tail)];
		return r;
	endfunction

	function automatic cbdq_pkg::elem_t pick_element();
		case ($urandom_range(15))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin
		deque_view_t want;
		if (done) begin
			if (pend_wr == pend_rd) begin
				$error("result with no transaction pending");
				error_count++;
			end else begin
				want = expected_views[pend_rd % PEND_DEPTH];
				pend_rd++;
				check_field("front_value", want.front, front_value);
				check_field("back_value", want.back, back_value);
				check_field("fill_count", want.fill, fill_count);
				check_field("empty", want.empty, empty);
				check_field("is_full", want.full, is_full);
				check_field("status", want.stat, status);
			end
		end
	end

	task automatic send_item(input cbdq_pkg::func_t f, input cbdq_pkg::elem_t v);
		int unsigned gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
		if (gap != 0) begin
			start <= 1'b0;
			func  <= cbdq_pkg::func_t'($urandom_range(7));
			value <= $urandom;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func  <= f;
		value <= v;
		do @(posedge clk); while (busy);
		expected_views[pend_wr % PEND_DEPTH] = apply_deque_op(f, v);
		pend_wr++;
	endtask

	task automatic drain_results(input int unsigned tail_cycles);
		start <= 1'b0;
		while (pend_wr != pend_rd) @(posedge clk);
		repeat (tail_cycles) @(posedge clk);
	endtask

	task automatic send_random_push();
		send_item($urandom_range(1) ? cbdq_pkg::OP_ADD_FRONT : cbdq_pkg::OP_ADD_BACK,
			pick_element());
	endtask

	task automatic send_random_pop();
		send_item($urandom_range(1) ? cbdq_pkg::OP_DROP_FRONT : cbdq_pkg::OP_DROP_BACK,
			pick_element());
	endtask

	task automatic send_random_idle_op();
		case ($urandom_range(2))
			0: send_item(cbdq_pkg::OP_NONE, pick_element());
			1: send_item(OP_SPARE_A, pick_element());
			default: send_item(OP_SPARE_B, pick_element());
		endcase
	endtask

	task automatic test_directed();
		send_item(cbdq_pkg::OP_NONE, 32'hFFFF_FFFF);
		send_item(cbdq_pkg::OP_DROP_FRONT, 32'h0);
		send_item(cbdq_pkg::OP_DROP_BACK, 32'h0);
		send_item(cbdq_pkg::OP_CLEAR, 32'h1234_5678);
		send_item(cbdq_pkg::OP_ADD_BACK, 32'h7FFF_FFFF);
		send_item(cbdq_pkg::OP_ADD_FRONT, 32'h8000_0000);
		send_item(cbdq_pkg::OP_ADD_BACK, 32'h0000_0000);
		send_item(cbdq_pkg::OP_ADD_FRONT, 32'hFFFF_FFFF);
		send_item(cbdq_pkg::OP_NONE, 32'h0);
		send_item(OP_SPARE_A, $urandom);
		send_item(OP_SPARE_B, $urandom);
		send_item(cbdq_pkg::OP_DROP_FRONT, $urandom);
		send_item(cbdq_pkg::OP_DROP_BACK, $urandom);
		send_item(cbdq_pkg::OP_ADD_BACK, 32'h5555_5555);
		send_item(cbdq_pkg::OP_DROP_BACK, 32'h0);
		send_item(cbdq_pkg::OP_DROP_FRONT, 32'h0);
		send_item(cbdq_pkg::OP_DROP_BACK, 32'h0);
		send_item(cbdq_pkg::OP_DROP_BACK, 32'h0);
		send_item(cbdq_pkg::OP_ADD_FRONT, 32'hAAAA_AAAA);
		send_item(cbdq_pkg::OP_CLEAR, 32'h0);
		send_item(cbdq_pkg::OP_ADD_FRONT, 32'h0000_0001);
		send_item(cbdq_pkg::OP_DROP_BACK, 32'h0);
		drain_results(0);
	endtask

	task automatic test_fill_and_drain();
		while (shadow_fill() < cbdq_pkg::MAX_ELEMENTS) begin
			if ($urandom_range(99) < 85) begin
				send_random_push();
			end else if ($urandom_range(1)) begin
				send_random_pop();
			end else begin
				send_random_idle_op();
			end
		end
		send_item(cbdq_pkg::OP_ADD_FRONT, pick_element());
		send_item(cbdq_pkg::OP_ADD_BACK, pick_element());
		drain_results(0);
		send_item(cbdq_pkg::OP_ADD_BACK, pick_element());
		send_item(cbdq_pkg::OP_NONE, pick_element());
		while (shadow_fill() > 0) begin
			if ($urandom_range(99) < 85) begin
				send_random_pop();
			end else if ($urandom_range(1)) begin
				send_random_push();
			end else begin
				send_random_idle_op();
			end
		end
		send_item(cbdq_pkg::OP_DROP_FRONT, pick_element());
		send_item(cbdq_pkg::OP_DROP_BACK, pick_element());
	endtask

	task automatic test_mixed(input int unsigned count);
		int unsigned pick;
		for (int unsigned i = 0; i < count; i++) begin
			if (i == count / 2) begin
				drain_results(0);
			end
			pick = $urandom_range(99);
			if (pick < 40) begin
				send_random_push();
			end else if (pick < 75) begin
				send_random_pop();
			end else if (pick < 78) begin
				send_item(cbdq_pkg::OP_CLEAR, pick_element());
			end else begin
				send_random_idle_op();
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_pct = 6;
		test_directed();
		test_fill_and_drain();
		idle_pct = 84;
		test_mixed(200);
		idle_pct = 0;
		test_mixed(200);
		drain_results(8);
		if (error_count == 0) begin
			$display("PASS circular_buffer_deque_unit");
		end else begin
			$display("FAIL circular_buffer_deque_unit");
		end
		$finish;
	end

endmodule

// ===== circular_buffer_deque_unit.f =====
rtl/cbdq_pkg.sv
rtl/cbdq_ram.sv
rtl/circular_buffer_deque_unit.sv
tb/sv/testbench.sv
